// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rgb to hsv rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/rgb2hsv_pkg.sv
// types and constants of the rgb to hsv converter
package rgb2hsv_pkg;

	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned HUE_W       = 17;
	localparam int unsigned SAT_W       = 17;
	localparam int unsigned BASE_W      = 11;   // sector offset, up to 6 * 255
	localparam int unsigned DIV_NUM_W   = 25;
	localparam int unsigned DIV_DEN_W   = CHAN_W;
	localparam int unsigned QUOT_W      = 17;
	localparam int unsigned RECIP_SHIFT = DIV_NUM_W;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam int unsigned DEN_COUNT   = 1 << DIV_DEN_W;

	// start to done, in clock edges
	localparam int unsigned PIPE_LAT    = 7;

	localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(92160);   // 360 degrees * 256
	localparam logic [SAT_W-1:0] SAT_ONE  = SAT_W'(65536);

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue_deg_q8;
		logic [SAT_W-1:0]  sat_q16;
		logic [CHAN_W-1:0] value_out;
	} hsv_t;

	// front end result: dividends, divisors and sideband
	typedef struct packed {
		logic [DIV_NUM_W-1:0] hue_num;
		logic [DIV_NUM_W-1:0] sat_num;
		logic [CHAN_W-1:0]    delta;
		logic [CHAN_W-1:0]    value;
		logic                 grey;
	} front_t;

	typedef struct packed {
		logic [CHAN_W-1:0] value;
		logic              grey;
	} side_t;

endpackage

// File: hw/rtl/rgb2hsv_front.sv
// max/min, sector offset and rounded dividends for hue and saturation
module rgb2hsv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rgb2hsv_pkg::pixel_t pix,
	output logic                out_valid,
	output rgb2hsv_pkg::front_t out
);
	import rgb2hsv_pkg::*;

	logic [CHAN_W-1:0] mx, mn, d;
	logic [BASE_W-1:0] base;
	logic [BASE_W-1:0] d_w;

	logic              valid_s1;
	logic [CHAN_W-1:0] value_s1, delta_s1;
	logic [BASE_W-1:0] base_s1;
	logic              grey_s1;

	logic              valid_s2;
	front_t            out_s2;

	always_comb begin
		mx = pix.red_in;
		mn = pix.red_in;
		if (pix.green_in > mx) mx = pix.green_in;
		if (pix.blue_in > mx) mx = pix.blue_in;
		if (pix.green_in < mn) mn = pix.green_in;
		if (pix.blue_in < mn) mn = pix.blue_in;
		d   = mx - mn;
		d_w = BASE_W'(d);
		// red wins ties, then green
		priority if (mx == pix.red_in) begin
			if (pix.green_in >= pix.blue_in)
				base = BASE_W'(pix.green_in - pix.blue_in);
			else
				base = (d_w << 2) + (d_w << 1) - BASE_W'(pix.blue_in - pix.green_in);
		end else if (mx == pix.green_in) begin
			base = (d_w << 1) + BASE_W'(pix.blue_in) - BASE_W'(pix.red_in);
		end else begin
			base = (d_w << 2) + BASE_W'(pix.red_in) - BASE_W'(pix.green_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		value_s1 <= mx;
		delta_s1 <= d;
		base_s1  <= base;
		grey_s1  <= (d == '0);
		// 15360 = 2^14 - 2^10; half divisor added for round to nearest
		out_s2.hue_num <= (DIV_NUM_W'(base_s1) << 14) - (DIV_NUM_W'(base_s1) << 10)
			+ DIV_NUM_W'(delta_s1 >> 1);
		out_s2.sat_num <= (DIV_NUM_W'(delta_s1) << 16) + DIV_NUM_W'(value_s1 >> 1);
		out_s2.delta   <= delta_s1;
		out_s2.value   <= value_s1;
		out_s2.grey    <= grey_s1;
	end

	assign out_valid = valid_s2;
	assign out       = out_s2;

endmodule

// File: hw/rtl/rgb2hsv_div.sv
// pipelined divide by 8-bit divisor: reciprocal table, multiply, one correction step
module rgb2hsv_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [rgb2hsv_pkg::DIV_NUM_W-1:0]   num,
	input  logic [rgb2hsv_pkg::DIV_DEN_W-1:0]   den,
	output logic                                out_valid,
	output logic [rgb2hsv_pkg::QUOT_W-1:0]      quot
);
	import rgb2hsv_pkg::*;

	logic [RECIP_W-1:0] recip_tbl [DEN_COUNT];

	// floor(2^25 / den); entry zero only serves grey items, whose results are forced to zero
	for (genvar i = 0; i < DEN_COUNT; i++) begin : g_recip
		localparam int unsigned Divisor = (i == 0) ? 1 : i;
		localparam logic [RECIP_W-1:0] RecipVal =
			(i == 0) ? '0 : RECIP_W'((64'd1 << RECIP_SHIFT) / Divisor);
		assign recip_tbl[i] = RecipVal;
	end

	logic                           valid_s1, valid_s2, valid_s3, valid_s4;
	logic [RECIP_W-1:0]             recip_s1;
	logic [DIV_NUM_W-1:0]           num_s1, num_s2, num_s3;
	logic [DIV_DEN_W-1:0]           den_s1, den_s2, den_s3;
	logic [QUOT_W-1:0]              qest_s2, qest_s3, quot_s4;
	logic [DIV_NUM_W-1:0]           prod_s3;
	logic [DIV_NUM_W+RECIP_W-1:0]   prod;
	logic [DIV_NUM_W-1:0]           rem;

	// estimate is the true quotient or one below it
	assign prod = (DIV_NUM_W+RECIP_W)'(num_s1) * (DIV_NUM_W+RECIP_W)'(recip_s1);
	assign rem  = num_s3 - prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		recip_s1 <= recip_tbl[den];
		num_s1   <= num;
		den_s1   <= den;

		qest_s2  <= prod[RECIP_SHIFT +: QUOT_W];
		num_s2   <= num_s1;
		den_s2   <= den_s1;

		prod_s3  <= DIV_NUM_W'(qest_s2) * DIV_NUM_W'(den_s2);
		qest_s3  <= qest_s2;
		num_s3   <= num_s2;
		den_s3   <= den_s2;

		quot_s4  <= qest_s3 + QUOT_W'(rem >= DIV_NUM_W'(den_s3));
	end

	assign out_valid = valid_s4;
	assign quot      = quot_s4;

endmodule

// File: hw/rtl/rgb_to_hsv_converter.sv
// top level of the rgb to hsv converter
//
//  channel  | ports                   | handshake
//  ---------+-------------------------+--------------------------------------
//  pixel in | start, busy, pixel      | item taken when start high, busy low
//  hsv out  | done, result            | result valid for the one done cycle
//
// one item per clock while busy is low; each result appears at done after the
// 2 front stages, the two reciprocal dividers (4 stages, side by side)
// and the output register
// busy is high during reset and for the first clock after it, then stays low
// the receiver cannot stall, so no pipeline stage ever holds
// reset clears valid bits and sets busy; payload registers are not reset
module rgb_to_hsv_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rgb2hsv_pkg::pixel_t pixel,
	output logic                done,
	output rgb2hsv_pkg::hsv_t   result
);
	import rgb2hsv_pkg::*;
	`include "assert_macros.svh"

	logic busy_q;
	logic accept;

	logic   front_valid;
	front_t front;

	logic                hue_div_valid, sat_div_valid;
	logic [QUOT_W-1:0]   hue_quot, sat_quot;

	// sideband that travels alongside the dividers
	side_t side_s3, side_s4, side_s5, side_s6;

	logic              done_s7;
	hsv_t              result_s7;
	logic [HUE_W-1:0]  hue_wrapped;

	// hold off the first clock after reset so nothing enters mid-reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// stages 1 and 2: max/min, sector, rounded dividends
	rgb2hsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.pix       (pixel),
		.out_valid (front_valid),
		.out       (front)
	);

	// stages 3 to 6: hue = (15360 * base + d/2) / d
	rgb2hsv_div u_hue_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.num       (front.hue_num),
		.den       (front.delta),
		.out_valid (hue_div_valid),
		.quot      (hue_quot)
	);

	// stages 3 to 6: saturation = (d * 65536 + max/2) / max
	rgb2hsv_div u_sat_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.num       (front.sat_num),
		.den       (front.value),
		.out_valid (sat_div_valid),
		.quot      (sat_quot)
	);

	always_ff @(posedge clk) begin
		side_s3 <= '{value: front.value, grey: front.grey};
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
	end

	// a hue that rounds up to a full turn wraps to zero
	assign hue_wrapped = (hue_quot >= HUE_FULL) ? (hue_quot - HUE_FULL) : hue_quot;

	// stage 7: output register, grey pixels forced to zero hue and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= hue_div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s7.hue_deg_q8 <= side_s6.grey ? '0 : hue_wrapped;
		result_s7.sat_q16    <= side_s6.grey ? '0 : sat_quot;
		result_s7.value_out  <= side_s6.value;
	end

	assign done   = done_s7;
	assign result = result_s7;

	`ASSERT_IMPL(a_done_latency, clk, arst_n, 1'b1, done == $past(accept, PIPE_LAT))
	`ASSERT_IMPL(a_div_lockstep, clk, arst_n, 1'b1, hue_div_valid == sat_div_valid)
	`ASSERT_IMPL(a_out_range, clk, arst_n, done, (result.hue_deg_q8 < HUE_FULL) && (result.sat_q16 <= SAT_ONE))
	`ASSERT_IMPL(a_grey_hue, clk, arst_n, done && (result.sat_q16 == '0), result.hue_deg_q8 == '0)
	`ASSERT_NEXT(a_busy_stays_low, clk, arst_n, !busy, !busy)

endmodule

// File: test/hsv_checker.sv
// checker for the rgb to hsv converter: predicts each result and compares it
`timescale 1ns / 1ps

module hsv_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  rgb2hsv_pkg::pixel_t pixel,
	input  logic                done,
	input  rgb2hsv_pkg::hsv_t   result,
	output int unsigned         mismatches,
	output int unsigned         outstanding
);

	import rgb2hsv_pkg::*;

	localparam int unsigned DEG60_Q8 = 60 * 256;

	hsv_t        hsv_expected[$];
	int unsigned mismatch_cnt;
	int unsigned pending_cnt;

	assign mismatches  = mismatch_cnt;
	assign outstanding = pending_cnt;

	function automatic hsv_t hsv_of_pixel(input pixel_t p);
		int unsigned r, g, b, mx, mn, delta, sector, hue, sat;
		hsv_t o;
		r = p.red_in;
		g = p.green_in;
		b = p.blue_in;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		hue = 0;
		sat = 0;
		if (delta != 0) begin
			// sector offset n + k*delta, red checked first, then green
			if (mx == r) begin
				if (g >= b) sector = g - b;
				else sector = 6 * delta - (b - g);
			end else if (mx == g) begin
				sector = 2 * delta + b - r;
			end else begin
				sector = 4 * delta + r - g;
			end
			hue = (DEG60_Q8 * sector + delta / 2) / delta;
			if (hue >= int'(HUE_FULL)) hue -= int'(HUE_FULL);
			sat = (delta * int'(SAT_ONE) + mx / 2) / mx;
		end
		o.hue_deg_q8 = HUE_W'(hue);
		o.sat_q16    = SAT_W'(sat);
		o.value_out  = CHAN_W'(mx);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hsv_t want;
		if (!arst_n) begin
			hsv_expected.delete();
			mismatch_cnt <= 0;
			pending_cnt  <= 0;
		end else begin
			// result leaves before the new item is queued, latency is never zero
			if (done) begin
				if (hsv_expected.size() == 0) begin
					$display("%0t: result with nothing pending: hue %0d sat %0d value %0d",
						$time, result.hue_deg_q8, result.sat_q16, result.value_out);
					mismatch_cnt <= mismatch_cnt + 1;
				end else begin
					want = hsv_expected.pop_front();
					if (result !== want) begin
						if (result.hue_deg_q8 !== want.hue_deg_q8)
							$display("%0t: hue_deg_q8 expected %0d actual %0d",
								$time, want.hue_deg_q8, result.hue_deg_q8);
						if (result.sat_q16 !== want.sat_q16)
							$display("%0t: sat_q16 expected %0d actual %0d",
								$time, want.sat_q16, result.sat_q16);
						if (result.value_out !== want.value_out)
							$display("%0t: value_out expected %0d actual %0d",
								$time, want.value_out, result.value_out);
						mismatch_cnt <= mismatch_cnt + 1;
					end
				end
			end
			if (start && !busy) hsv_expected.push_back(hsv_of_pixel(pixel));
			pending_cnt <= $unsigned(hsv_expected.size());
		end
	end

endmodule

// File: test/tb_rgb_to_hsv_converter.sv
// testbench top for the rgb to hsv converter: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;

	import rgb2hsv_pkg::*;

	// cycles with no item taken and no result seen before giving up
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 500;

	// kinds of random pixel
	typedef enum int unsigned {
		PIX_UNIFORM,
		PIX_NEAR_GREY,
		PIX_TIED,
		PIX_EXTREME
	} pix_kind_e;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	pixel_t      pixel;
	logic        done;
	hsv_t        result;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned idle_cycles;

	rgb_to_hsv_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	hsv_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixel       (pixel),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: any item taken or result seen counts as progress
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("** rgb_to_hsv_converter: FAILED **");
				$finish;
			end
		end
	end

	function automatic pixel_t rgb(input int unsigned r, input int unsigned g,
		input int unsigned b);
		pixel_t p;
		p.red_in   = CHAN_W'(r);
		p.green_in = CHAN_W'(g);
		p.blue_in  = CHAN_W'(b);
		return p;
	endfunction

	// most gaps are zero or short, an occasional one is long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	function automatic pixel_t random_pixel();
		pix_kind_e   kind;
		int unsigned base, spread, roll;
		pixel_t      p;
		roll = $urandom_range(99);
		if (roll < 40) kind = PIX_UNIFORM;
		else if (roll < 60) kind = PIX_NEAR_GREY;
		else if (roll < 80) kind = PIX_TIED;
		else kind = PIX_EXTREME;
		p = pixel_t'($urandom);
		case (kind)
			PIX_NEAR_GREY: begin
				// tiny delta makes the divisions the hardest to round
				base   = $urandom_range(255);
				spread = $urandom_range(3);
				p = rgb(base, (base + $urandom_range(spread)) % 256,
					(base + 256 - $urandom_range(spread)) % 256);
			end
			PIX_TIED: begin
				// two channels equal, exercises the max priority order
				case ($urandom_range(2))
					0: p.green_in = p.red_in;
					1: p.blue_in  = p.green_in;
					default: p.blue_in = p.red_in;
				endcase
			end
			PIX_EXTREME: begin
				p = rgb($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1),
					$urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1),
					$urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
			end
			default: ;
		endcase
		return p;
	endfunction

	// start goes low only for a gap, so it never toggles within one step
	task automatic send_pixel(input pixel_t p, input int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			pixel <= pixel_t'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		pixel <= p;
		// busy sampled at the edge, before the block updates it
		do @(posedge clk); while (busy);
	endtask

	initial begin
		pixel_t directed[$];
		bit     bursting;

		arst_n = 1'b0;
		start  = 1'b0;
		pixel  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// black, white and a mid grey: hue and saturation must be zero
		directed.push_back(rgb(0, 0, 0));
		directed.push_back(rgb(255, 255, 255));
		directed.push_back(rgb(128, 128, 128));
		// primaries: full saturation, one per sector
		directed.push_back(rgb(255, 0, 0));
		directed.push_back(rgb(0, 255, 0));
		directed.push_back(rgb(0, 0, 255));
		// tied maxima: red beats green and blue, green beats blue
		directed.push_back(rgb(255, 255, 0));
		directed.push_back(rgb(255, 0, 255));
		directed.push_back(rgb(0, 255, 255));
		directed.push_back(rgb(200, 200, 100));
		// red sector with blue above green, hue between 300 and 360 degrees
		directed.push_back(rgb(255, 0, 1));
		directed.push_back(rgb(255, 0, 254));
		directed.push_back(rgb(10, 3, 4));
		// smallest deltas and smallest max, where rounding bites
		directed.push_back(rgb(1, 0, 0));
		directed.push_back(rgb(0, 1, 0));
		directed.push_back(rgb(0, 0, 1));
		directed.push_back(rgb(255, 254, 254));
		directed.push_back(rgb(128, 127, 127));
		directed.push_back(rgb(3, 2, 1));
		directed.push_back(rgb(254, 255, 253));
		// min of zero gives saturation of exactly one
		directed.push_back(rgb(17, 0, 9));
		directed.push_back(rgb(100, 50, 0));

		foreach (directed[i]) send_pixel(directed[i], pick_gap());

		// random items: every third block of fifty runs back to back
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			bursting = ((i / 50) % 3) == 1;
			send_pixel(random_pixel(), bursting ? 0 : pick_gap());
		end

		@(negedge clk);
		start <= 1'b0;

		// drain, then a few cycles more for any stray result
		while (outstanding != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("** rgb_to_hsv_converter: PASSED **");
		end else begin
			$display("** rgb_to_hsv_converter: FAILED **");
		end
		$finish;
	end

endmodule
